// ===== rtl/core/pm_pkg.sv =====
package pm_pkg;

    localparam int DRAW_BITS_DEF = 16;
    localparam int CFG_W         = 17;
    localparam int REG_IDX_W     = 1;
    localparam int LOG_FRAC      = 24;
    localparam int LOG_W         = 30;

    localparam logic [REG_IDX_W-1:0] REG_PROB = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_ETA  = 1'd1;

    localparam logic [16:0] PROB_RESET = 17'd2048;
    localparam logic [15:0] ETA_RESET  = 16'd5120;

    typedef struct packed {
        logic signed [31:0] gene_value;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic [15:0]        apply_draw;
        logic [15:0]        shape_draw;
    } pm_in_t;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic               was_mutated;
        logic               bad_bounds;
    } pm_out_t;

    // per-gene data that rides alongside the arithmetic
    typedef struct packed {
        logic signed [31:0] y;
        logic signed [31:0] yc;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [31:0]        d;
        logic [31:0]        rq;
        logic               lower;
        logic               mut;
        logic               bad;
    } pm_side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(-2^(idx-24)) in Q32, built by repeated floor square roots from 0.5
    function automatic logic [31:0] exp2_root(input int idx);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 23; j >= idx; j--) begin
            c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

endpackage

// ===== rtl/core/polynomial_mutation.sv =====
// channel  ports                      word
// config   cfg_we/cfg_index/cfg_data  register write, no handshake wait
// input    s_valid/s_ready/s_data     one gene with bounds and two draws
// output   m_valid/m_ready/m_data     mutated value and flags
//
// One gene enters per cycle unless a held output word stalls the pipeline.
// The pipeline is built from the two 24-step log2 and exp2 chains (twice each) and
// the two bit-per-stage restoring dividers.
// Reset is synchronous, active low; it clears valid bits and the config registers.
// A held output word stalls the whole pipeline; nothing is dropped.
module polynomial_mutation import pm_pkg::*; #(
    parameter int DRAW_BITS = DRAW_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pm_in_t               s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pm_out_t              m_data
);

    localparam int SIDE_W = $bits(pm_side_t);
    localparam int D1_N   = 33;
    localparam int D2_N   = LOG_W;
    localparam logic [15:0] DRAW_MASK =
        (DRAW_BITS >= 16) ? 16'hFFFF : 16'((1 << DRAW_BITS) - 1);

    logic [16:0] prob_reg;
    logic [15:0] eta_reg;
    logic [16:0] eta1;
    logic        en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prob_reg <= PROB_RESET;
            eta_reg  <= ETA_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PROB: prob_reg <= cfg_data[16:0];
                REG_ETA:  eta_reg  <= cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    assign eta1 = 17'(eta_reg) + 17'd256;

    logic     m_valid_reg;
    pm_out_t  m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // front: bounds check, mutate decision, clamp, distance
    logic signed [31:0] y_f, lo_f, hi_f, yc_f;
    logic [15:0] apply_m, shape_m;
    logic [49:0] apply_sc, prob_sc;
    logic [31:0] d_f, rq_f, num_f;
    logic        bad_f, lower_f;
    pm_side_t    side_f;

    always_comb begin
        y_f      = s_data.gene_value;
        lo_f     = s_data.lower_bound;
        hi_f     = s_data.upper_bound;
        apply_m  = s_data.apply_draw & DRAW_MASK;
        shape_m  = s_data.shape_draw & DRAW_MASK;
        apply_sc = {18'd0, apply_m, 16'd0};
        prob_sc  = 50'(prob_reg) << DRAW_BITS;
        bad_f    = (hi_f <= lo_f);
        if (y_f < lo_f) begin
            yc_f = lo_f;
        end else if (y_f > hi_f) begin
            yc_f = hi_f;
        end else begin
            yc_f = y_f;
        end
        d_f     = 32'(hi_f - lo_f);
        rq_f    = 32'(shape_m) << (32 - DRAW_BITS);
        lower_f = (rq_f <= 32'h8000_0000);
        num_f   = lower_f ? 32'(hi_f - yc_f) : 32'(yc_f - lo_f);
        side_f.y     = y_f;
        side_f.yc    = yc_f;
        side_f.lo    = lo_f;
        side_f.hi    = hi_f;
        side_f.d     = d_f;
        side_f.rq    = rq_f;
        side_f.lower = lower_f;
        side_f.mut   = !bad_f && (apply_sc <= prob_sc);
        side_f.bad   = bad_f;
    end

    // divider 1: (num << 32) / d, one quotient bit per stage
    logic        d1_valid_reg [0:D1_N];
    logic [31:0] d1_rem_reg   [0:D1_N];
    logic [32:0] d1_q_reg     [0:D1_N];
    pm_side_t    d1_side_reg  [0:D1_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg[0] <= 1'b0;
        end else if (en) begin
            d1_valid_reg[0] <= s_valid;
        end
        if (en) begin
            d1_rem_reg[0]  <= num_f;
            d1_q_reg[0]    <= '0;
            d1_side_reg[0] <= side_f;
        end
    end

    for (genvar j = 0; j < D1_N; j++) begin : g_div1
        logic [32:0] t;
        logic        ge;
        if (j == 0) begin : g_first
            assign t = {1'b0, d1_rem_reg[0]};
        end else begin : g_rest
            assign t = {d1_rem_reg[j], 1'b0};
        end
        assign ge = (t >= {1'b0, d1_side_reg[j].d});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d1_valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                d1_valid_reg[j+1] <= d1_valid_reg[j];
            end
            if (en) begin
                d1_rem_reg[j+1]  <= ge ? 32'(t - {1'b0, d1_side_reg[j].d}) : t[31:0];
                d1_q_reg[j+1]    <= {d1_q_reg[j][31:0], ge};
                d1_side_reg[j+1] <= d1_side_reg[j];
            end
        end
    end

    // first power: base^(eta+1)
    logic              la_valid, la_zero;
    logic [LOG_W-1:0]  la_l;
    logic [SIDE_W-1:0] la_side;

    pm_log2 #(.SIDE_W(SIDE_W)) u_log_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d1_valid_reg[D1_N]),
        .x         (d1_q_reg[D1_N]),
        .in_side   (d1_side_reg[D1_N]),
        .out_valid (la_valid),
        .lval      (la_l),
        .zero      (la_zero),
        .out_side  (la_side)
    );

    logic [46:0]       e1_prod;
    logic              e1_valid_reg, e1_zero_reg;
    logic [38:0]       e1_reg;
    logic [SIDE_W-1:0] e1_side_reg;

    assign e1_prod = la_l * eta1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
        end else if (en) begin
            e1_valid_reg <= la_valid;
        end
        if (en) begin
            e1_reg      <= e1_prod[46:8];
            e1_zero_reg <= la_zero;
            e1_side_reg <= la_side;
        end
    end

    logic              xa_valid;
    logic [32:0]       xa_r;
    logic [SIDE_W-1:0] xa_side_w;
    pm_side_t          xa_side;

    pm_exp2 #(.SIDE_W(SIDE_W)) u_exp_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e1_valid_reg),
        .f         (e1_reg[LOG_FRAC-1:0]),
        .k         (e1_reg[29:24]),
        .kill      (e1_zero_reg || (e1_reg[38:24] > 15'd32)),
        .in_side   (e1_side_reg),
        .out_valid (xa_valid),
        .r         (xa_r),
        .out_side  (xa_side_w)
    );

    assign xa_side = xa_side_w;

    // blend with the shape draw
    logic [32:0] va_a;
    logic [65:0] va_prod;
    logic        v1_valid_reg;
    logic [32:0] v1_mq_reg;
    pm_side_t    v1_side_reg;

    assign va_a = xa_side.lower ? (33'h1_0000_0000 - {xa_side.rq, 1'b0})
                                : {xa_side.rq - 32'h8000_0000, 1'b0};
    assign va_prod = va_a * xa_r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
        end else if (en) begin
            v1_valid_reg <= xa_valid;
        end
        if (en) begin
            v1_mq_reg   <= va_prod[64:32];
            v1_side_reg <= xa_side;
        end
    end

    logic [31:0] rq_neg;
    logic [32:0] v_base;
    logic        v2_valid_reg;
    logic [32:0] v2_val_reg;
    pm_side_t    v2_side_reg;

    assign rq_neg = 32'd0 - v1_side_reg.rq;
    assign v_base = v1_side_reg.lower ? {v1_side_reg.rq, 1'b0} : {rq_neg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_valid_reg <= 1'b0;
        end else if (en) begin
            v2_valid_reg <= v1_valid_reg;
        end
        if (en) begin
            v2_val_reg  <= v_base + v1_mq_reg;
            v2_side_reg <= v1_side_reg;
        end
    end

    // second power: val^(1/(eta+1))
    logic              lb_valid, lb_zero;
    logic [LOG_W-1:0]  lb_l;
    logic [SIDE_W-1:0] lb_side;

    pm_log2 #(.SIDE_W(SIDE_W)) u_log_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_valid_reg),
        .x         (v2_val_reg),
        .in_side   (v2_side_reg),
        .out_valid (lb_valid),
        .lval      (lb_l),
        .zero      (lb_zero),
        .out_side  (lb_side)
    );

    // divider 2: (L << 8) / (eta+1); top eight dividend bits never exceed eta+1
    logic              d2_valid_reg [0:D2_N];
    logic [16:0]       d2_rem_reg   [0:D2_N];
    logic [D2_N-1:0]   d2_n_reg     [0:D2_N];
    logic [D2_N-1:0]   d2_q_reg     [0:D2_N];
    logic              d2_zero_reg  [0:D2_N];
    logic [SIDE_W-1:0] d2_side_reg  [0:D2_N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_valid_reg[0] <= 1'b0;
        end else if (en) begin
            d2_valid_reg[0] <= lb_valid;
        end
        if (en) begin
            d2_rem_reg[0]  <= 17'(lb_l[LOG_W-1:22]);
            d2_n_reg[0]    <= {lb_l[21:0], 8'd0};
            d2_q_reg[0]    <= '0;
            d2_zero_reg[0] <= lb_zero;
            d2_side_reg[0] <= lb_side;
        end
    end

    for (genvar j = 0; j < D2_N; j++) begin : g_div2
        logic [17:0] t;
        logic        ge;
        assign t  = {d2_rem_reg[j], d2_n_reg[j][D2_N-1]};
        assign ge = (t >= {1'b0, eta1});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d2_valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                d2_valid_reg[j+1] <= d2_valid_reg[j];
            end
            if (en) begin
                d2_rem_reg[j+1]  <= ge ? 17'(t - {1'b0, eta1}) : t[16:0];
                d2_n_reg[j+1]    <= {d2_n_reg[j][D2_N-2:0], 1'b0};
                d2_q_reg[j+1]    <= {d2_q_reg[j][D2_N-2:0], ge};
                d2_zero_reg[j+1] <= d2_zero_reg[j];
                d2_side_reg[j+1] <= d2_side_reg[j];
            end
        end
    end

    logic              xb_valid;
    logic [32:0]       xb_r;
    logic [SIDE_W-1:0] xb_side_w;
    pm_side_t          xb_side;

    pm_exp2 #(.SIDE_W(SIDE_W)) u_exp_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d2_valid_reg[D2_N]),
        .f         (d2_q_reg[D2_N][LOG_FRAC-1:0]),
        .k         (d2_q_reg[D2_N][29:24]),
        .kill      (d2_zero_reg[D2_N] || (d2_q_reg[D2_N][29:24] > 6'd32)),
        .in_side   (d2_side_reg[D2_N]),
        .out_valid (xb_valid),
        .r         (xb_r),
        .out_side  (xb_side_w)
    );

    assign xb_side = xb_side_w;

    // step = round((1 - pw) * d)
    logic [32:0] mag;
    logic [64:0] s_prod, s_round;
    logic        st_valid_reg;
    logic [32:0] st_step_reg;
    pm_side_t    st_side_reg;

    assign mag     = 33'h1_0000_0000 - xb_r;
    assign s_prod  = mag * xb_side.d;
    assign s_round = s_prod + 65'h8000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (en) begin
            st_valid_reg <= xb_valid;
        end
        if (en) begin
            st_step_reg <= s_round[64:32];
            st_side_reg <= xb_side;
        end
    end

    // apply step, clamp, pick passthrough for unmutated words
    logic signed [33:0] yc_x, lo_x, hi_x, step_x, res_x, clamp_x;
    pm_out_t            out_next;

    always_comb begin
        yc_x   = 34'(st_side_reg.yc);
        lo_x   = 34'(st_side_reg.lo);
        hi_x   = 34'(st_side_reg.hi);
        step_x = $signed({1'b0, st_step_reg});
        res_x  = st_side_reg.lower ? (yc_x - step_x) : (yc_x + step_x);
        if (res_x < lo_x) begin
            clamp_x = lo_x;
        end else if (res_x > hi_x) begin
            clamp_x = hi_x;
        end else begin
            clamp_x = res_x;
        end
        out_next.new_value   = st_side_reg.mut ? clamp_x[31:0] : st_side_reg.y;
        out_next.was_mutated = st_side_reg.mut;
        out_next.bad_bounds  = st_side_reg.bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= st_valid_reg;
        end
        if (en) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/pm_log2.sv =====
module pm_log2 import pm_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [32:0]       x,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [LOG_W-1:0]  lval,
    output logic              zero,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [0:LOG_FRAC];
    logic [31:0]       m_reg     [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_reg [0:LOG_FRAC];
    logic [5:0]        p_reg     [0:LOG_FRAC];
    logic              zero_reg  [0:LOG_FRAC];
    logic [SIDE_W-1:0] side_reg  [0:LOG_FRAC];

    logic [5:0]  p_next;
    logic [31:0] m_next;

    // leading one and normalize to Q31
    always_comb begin
        p_next = '0;
        for (int b = 0; b < 33; b++) begin
            if (x[b]) p_next = 6'(b);
        end
        if (p_next >= 6'd31) begin
            m_next = 32'(x >> (p_next - 6'd31));
        end else begin
            m_next = 32'(x << (6'd31 - p_next));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            m_reg[0]    <= m_next;
            frac_reg[0] <= '0;
            p_reg[0]    <= p_next;
            zero_reg[0] <= (x == 33'd0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] t;
        assign sq = m_reg[i-1] * m_reg[i-1];
        assign t  = sq[63:31];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_reg[i-1];
            end
            if (en) begin
                m_reg[i]    <= t[32] ? t[32:1] : t[31:0];
                frac_reg[i] <= {frac_reg[i-1][LOG_FRAC-2:0], t[32]};
                p_reg[i]    <= p_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    logic              out_valid_reg;
    logic [LOG_W-1:0]  lval_reg;
    logic [LOG_W-1:0]  lval_next;
    logic              zero_out_reg;
    logic [SIDE_W-1:0] side_out_reg;

    assign lval_next = (LOG_W'(6'd32 - p_reg[LOG_FRAC]) << LOG_FRAC)
                     - LOG_W'(frac_reg[LOG_FRAC]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[LOG_FRAC];
        end
        if (en) begin
            lval_reg     <= lval_next;
            zero_out_reg <= zero_reg[LOG_FRAC];
            side_out_reg <= side_reg[LOG_FRAC];
        end
    end

    assign out_valid = out_valid_reg;
    assign lval      = lval_reg;
    assign zero      = zero_out_reg;
    assign out_side  = side_out_reg;

endmodule

// ===== rtl/core/pm_exp2.sv =====
module pm_exp2 import pm_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [LOG_FRAC-1:0] f,
    input  logic [5:0]          k,
    input  logic                kill,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [32:0]         r,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int LAST = LOG_FRAC - 1;
    localparam logic [31:0] ROOT_TOP = exp2_root(LAST);

    logic                valid_reg [0:LAST];
    logic [32:0]         r_reg     [0:LAST];
    logic [LOG_FRAC-1:0] f_reg     [0:LAST];
    logic [5:0]          k_reg     [0:LAST];
    logic                kill_reg  [0:LAST];
    logic [SIDE_W-1:0]   side_reg  [0:LAST];

    // first factor needs no multiply: 1.0 times the top root
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
        if (en) begin
            r_reg[0]    <= f[LAST] ? {1'b0, ROOT_TOP} : 33'h1_0000_0000;
            f_reg[0]    <= f;
            k_reg[0]    <= k;
            kill_reg[0] <= kill;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 1; i <= LAST; i++) begin : g_mul
        localparam logic [31:0] ROOT = exp2_root(LAST - i);
        logic [64:0] prod;
        assign prod = r_reg[i-1] * ROOT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_reg[i-1];
            end
            if (en) begin
                r_reg[i]    <= f_reg[i-1][LAST-i] ? prod[64:32] : r_reg[i-1];
                f_reg[i]    <= f_reg[i-1];
                k_reg[i]    <= k_reg[i-1];
                kill_reg[i] <= kill_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    logic              out_valid_reg;
    logic [32:0]       r_out_reg;
    logic [SIDE_W-1:0] side_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[LAST];
        end
        if (en) begin
            r_out_reg    <= kill_reg[LAST] ? 33'd0 : (r_reg[LAST] >> k_reg[LAST]);
            side_out_reg <= side_reg[LAST];
        end
    end

    assign out_valid = out_valid_reg;
    assign r         = r_out_reg;
    assign out_side  = side_out_reg;

endmodule

// ===== rtl/core/pm_checker.sv =====
module pm_props import pm_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input pm_out_t m_data
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    a_bad_no_mut: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_bounds |-> !m_data.was_mutated)
        else $error("bad bounds word marked as mutated");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind polynomial_mutation pm_props u_pm_props (.*);

// ===== tb/pm_checker.sv =====
`timescale 1ns / 1ps

module pm_checker import pm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  pm_in_t               s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  pm_out_t              m_data,
    output int                   fail_count,
    output int                   pending
);

    localparam logic [63:0] ONE_Q32  = 64'd1 << 32;
    localparam logic [63:0] HALF_Q32 = 64'd1 << 31;

    logic [16:0] prob_reg;
    logic [15:0] eta_reg;
    pm_out_t     expected_q[$];
    logic [31:0] root_tab[24];

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'd1 << 62;
        while (b > rem && b != 0) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // -log2 of a Q32 fraction, Q.24
    function automatic logic [63:0] minus_log2(input logic [63:0] x);
        int          p;
        logic [63:0] t;
        logic [63:0] m;
        logic [63:0] frac;
        p = 0;
        t = x;
        frac = 0;
        while (t > 1) begin
            t = t >> 1;
            p++;
        end
        m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= ONE_Q32) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(32 - p) << 24) - frac;
    endfunction

    function automatic logic [63:0] exp2_minus(input logic [63:0] e);
        logic [63:0] k;
        logic [63:0] r;
        k = e >> 24;
        r = ONE_Q32;
        if (k > 32) return 0;
        for (int i = 23; i >= 0; i--)
            if (e[i]) r = (r * root_tab[i]) >> 32;
        return r >> k;
    endfunction

    function automatic logic [63:0] frac_power(input logic [63:0] x, input logic [63:0] a,
                                               input logic [63:0] b);
        if (x == 0) return 0;
        return exp2_minus(minus_log2(x) * a / b);
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        if (a == ONE_Q32) return b;
        return (a * b) >> 32;
    endfunction

    function automatic pm_out_t mutate_gene(input pm_in_t g);
        pm_out_t     r;
        logic signed [63:0] y, lo, hi, res;
        logic [63:0] d, rq, p, val, pw, mag, stp, eta1;
        y  = g.gene_value;
        lo = g.lower_bound;
        hi = g.upper_bound;
        eta1 = 64'(eta_reg) + 256;
        res = y;
        r = '0;
        if (hi <= lo) begin
            r.bad_bounds = 1'b1;
        end else if ({48'd0, g.apply_draw} <= {47'd0, prob_reg}) begin
            if (y < lo) y = lo;
            if (y > hi) y = hi;
            d  = 64'(hi - lo);
            rq = 64'(g.shape_draw) << 16;
            if (rq <= HALF_Q32) begin
                p   = frac_power((64'(hi - y) << 32) / d, eta1, 256);
                val = 2 * rq + qmul(ONE_Q32 - 2 * rq, p);
            end else begin
                p   = frac_power((64'(y - lo) << 32) / d, eta1, 256);
                val = 2 * (ONE_Q32 - rq) + qmul(2 * (rq - HALF_Q32), p);
            end
            pw  = frac_power(val, 256, eta1);
            mag = ONE_Q32 - pw;
            stp = (mag * d + HALF_Q32) >> 32;
            res = (rq <= HALF_Q32) ? y - $signed(stp) : y + $signed(stp);
            if (res < lo) res = lo;
            if (res > hi) res = hi;
            r.was_mutated = 1'b1;
        end
        r.new_value = res[31:0];
        return r;
    endfunction

    initial begin
        logic [63:0] c;
        c = HALF_Q32;
        for (int i = 23; i >= 0; i--) begin
            c = floor_sqrt(c << 32);
            root_tab[i] = c[31:0];
        end
    end

    always @(posedge aclk) begin
        pm_out_t e;
        if (!aresetn) begin
            prob_reg <= PROB_RESET;
            eta_reg  <= ETA_RESET;
            expected_q.delete();
            fail_count = 0;
            pending <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_PROB) prob_reg <= cfg_data;
                else if (cfg_index == REG_ETA) eta_reg <= cfg_data[15:0];
            end
            if (s_valid && s_ready) expected_q.push_back(mutate_gene(s_data));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected word: new_value %0d", $signed(m_data.new_value));
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_data.new_value !== e.new_value) begin
                        $error("new_value: expected %0d, actual %0d",
                               $signed(e.new_value), $signed(m_data.new_value));
                        fail_count++;
                    end
                    if (m_data.was_mutated !== e.was_mutated) begin
                        $error("was_mutated: expected %0b, actual %0b",
                               e.was_mutated, m_data.was_mutated);
                        fail_count++;
                    end
                    if (m_data.bad_bounds !== e.bad_bounds) begin
                        $error("bad_bounds: expected %0b, actual %0b",
                               e.bad_bounds, m_data.bad_bounds);
                        fail_count++;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pm_pkg::*;

    localparam int LATENCY   = 172;
    localparam int RAND_GENES = 830;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_PROB;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    pm_in_t               s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    pm_out_t              m_data;
    int                   fail_count;
    int                   pending;
    logic                 rx_calm = 1'b0;
    logic                 rx_hold = 1'b0;

    polynomial_mutation uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    pm_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stall bursts, one long hold on request, none when calm
    initial begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_all();
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic send_gene(input pm_in_t g, input bit gaps);
        int n;
        if (gaps && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= g;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic pm_in_t random_gene();
        pm_in_t g;
        logic signed [31:0] a, b, t;
        g.apply_draw = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3000))
                                                   : 16'($urandom);
        g.shape_draw = ($urandom_range(0, 9) == 0) ? 16'h8000 : 16'($urandom);
        a = any_word();
        b = any_word();
        if ($urandom_range(0, 9) != 0 && a > b) begin
            t = a;
            a = b;
            b = t;
        end
        g.lower_bound = a;
        g.upper_bound = b;
        if ($urandom_range(0, 4) == 0) g.gene_value = any_word();
        else g.gene_value = a + $signed(32'($urandom_range(0, 1000)))
                            * ((b - a) / 1000);
        return g;
    endfunction

    initial begin
        pm_in_t g;
        logic [16:0] probs[5];
        logic [15:0] etas[5];
        probs = '{17'd65536, 17'd0, 17'd2048, 17'd32768, 17'd131071};
        etas  = '{16'd0, 16'd65535, 16'd5120, 16'd256, 16'($urandom)};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every gene with valid bounds mutates
        write_reg(REG_PROB, 17'd65536);
        write_reg(REG_ETA, 16'd5120);
        begin
            pm_in_t d[$];
            d.push_back('{32'sd0, -32'sd65536, 32'sd65536, 16'd0, 16'd0});
            d.push_back('{32'sd0, -32'sd65536, 32'sd65536, 16'hFFFF, 16'hFFFF});
            d.push_back('{32'sd0, -32'sd65536, 32'sd65536, 16'd100, 16'h8000});
            d.push_back('{32'sd0, -32'sd65536, 32'sd65536, 16'd100, 16'h8001});
            d.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd5, 16'd1});
            d.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd5, 16'hFFFE});
            d.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd5, 16'd3});
            d.push_back('{32'sd999999, 32'sd0, 32'sd10, 16'd7, 16'h4000}); // above upper
            d.push_back('{-32'sd999999, 32'sd0, 32'sd10, 16'd7, 16'hC000}); // below lower
            d.push_back('{32'sd5, 32'sd10, 32'sd10, 16'd0, 16'd0});         // equal bounds
            d.push_back('{32'sd5, 32'sd10, -32'sd10, 16'd0, 16'hFFFF});     // inverted
            d.push_back('{32'sd1, 32'sd0, 32'sd1, 16'd0, 16'h0001});
            d.push_back('{32'sh5555_5555, 32'sh2AAA_AAAA, 32'sh5555_5555, 16'hAAAA, 16'h5555});
            foreach (d[i]) send_gene(d[i], 1'b0);
        end
        s_valid <= 1'b0;
        drain_all();
        // probability zero: only a zero draw mutates
        write_reg(REG_PROB, 17'd0);
        write_reg(REG_ETA, 16'd0);
        send_gene('{32'sd0, -32'sd65536, 32'sd65536, 16'd0, 16'h2000}, 1'b0);
        send_gene('{32'sd0, -32'sd65536, 32'sd65536, 16'd1, 16'h2000}, 1'b0);
        send_gene('{32'sd0, -32'sd65536, 32'sd65536, 16'hFFFF, 16'h2000}, 1'b0);
        s_valid <= 1'b0;
        drain_all();

        // random phases under several register settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_PROB, probs[ph]);
            write_reg(REG_ETA, etas[ph]);
            if (ph == 1) rx_hold <= 1'b1;
            if (ph == 4) rx_calm <= 1'b1;
            for (int i = 0; i < RAND_GENES / 5; i++) begin
                g = random_gene();
                send_gene(g, ph != 4);
            end
            s_valid <= 1'b0;
            drain_all();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
